// ===== rtl/core/skset_pkg.sv =====
// Package for the sorted key set: sizes, cell operation codes, the link and
// control structs shared by the cell chain, and the controller state type.
// No dependencies.
`default_nettype none
package skset_pkg;

	localparam int CAPACITY = 32;
	localparam int KEY_W    = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OUT_W    = 6;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cell_op_t           op;
		logic [KEY_W-1:0]   key;
	} cell_ctrl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic [KEY_W-1:0]   entry;
		logic               valid;
		logic               ge;
	} cell_link_t;

	// where the cell sits relative to the fill level
	typedef struct packed {
		logic               valid;
		logic               tail;
	} cell_pos_t;

	typedef enum logic {
		ST_IDLE,
		ST_ERASE
	} ctrl_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/skset_cell.sv =====
// One slot of the sorted list: holds an entry, compares it against the key
// and shifts up (insert) or down (remove) from its neighbors. Uses skset_pkg.
`default_nettype none
module skset_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire skset_pkg::cell_ctrl_t ctrl,
	input  wire skset_pkg::cell_pos_t  pos,
	input  wire skset_pkg::cell_link_t lo,
	input  wire skset_pkg::cell_link_t hi,
	output skset_pkg::cell_link_t      link,
	output logic                       match
);

	logic [skset_pkg::KEY_W-1:0] entry_q;
	logic                        ge;

	assign ge    = pos.valid && (entry_q >= ctrl.key);
	assign match = pos.valid && (entry_q == ctrl.key);

	assign link.entry = entry_q;
	assign link.valid = pos.valid;
	assign link.ge    = ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			case (ctrl.op)
				skset_pkg::CELL_INSERT: begin
					// everything at or past the insertion point moves up one
					if (ge || pos.tail) begin
						entry_q <= lo.ge ? lo.entry : ctrl.key;
					end
				end
				skset_pkg::CELL_REMOVE: begin
					// first match sits at the lowest ge slot; close the gap
					if (ge) begin
						entry_q <= hi.valid ? hi.entry : '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/skset_ctrl.sv =====
// Sequencer for the sorted key set: accepts commands, keeps the fill count,
// steps an erase one removal per cycle and registers the result beat.
// Uses skset_pkg.
`default_nettype none
module skset_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          mode,
	input  wire logic [skset_pkg::KEY_W-1:0]   key,
	input  wire logic                          any_match,
	output logic                               busy,
	output skset_pkg::cell_ctrl_t              ctrl,
	output logic [skset_pkg::CNT_W-1:0]        count_q,
	output logic                               done_q,
	output logic                               dropped_q,
	output logic [skset_pkg::CNT_W-1:0]        removed_q
);

	skset_pkg::ctrl_state_t      state_q, state_d;
	logic [skset_pkg::KEY_W-1:0] key_q;
	logic                        accept;
	logic                        full;
	logic                        finish;

	assign accept = start && (state_q == skset_pkg::ST_IDLE);
	assign full   = (count_q >= skset_pkg::CNT_W'(skset_pkg::CAPACITY));

	always_comb begin
		state_d = state_q;
		case (state_q)
			skset_pkg::ST_IDLE: begin
				if (accept && mode) begin
					state_d = skset_pkg::ST_ERASE;
				end
			end
			skset_pkg::ST_ERASE: begin
				if (!any_match) begin
					state_d = skset_pkg::ST_IDLE;
				end
			end
			default: state_d = skset_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		ctrl.op  = skset_pkg::CELL_HOLD;
		ctrl.key = key;
		finish   = 1'b0;
		case (state_q)
			skset_pkg::ST_IDLE: begin
				if (accept && !mode && !full) begin
					ctrl.op = skset_pkg::CELL_INSERT;
				end
			end
			skset_pkg::ST_ERASE: begin
				busy     = 1'b1;
				ctrl.key = key_q;
				if (any_match) begin
					ctrl.op = skset_pkg::CELL_REMOVE;
				end else begin
					finish = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= skset_pkg::ST_IDLE;
			count_q   <= '0;
			done_q    <= 1'b0;
			dropped_q <= 1'b0;
			removed_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && !mode) || finish;
			case (ctrl.op)
				skset_pkg::CELL_INSERT: count_q <= count_q + 1'b1;
				skset_pkg::CELL_REMOVE: count_q <= count_q - 1'b1;
				default: begin
				end
			endcase
			if (accept) begin
				dropped_q <= !mode && full;
				removed_q <= '0;
			end else if (ctrl.op == skset_pkg::CELL_REMOVE) begin
				removed_q <= removed_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_key_set_insert_erase.sv =====
// Top level of the sorted key set: a chain of skset_cell slots under the
// skset_ctrl sequencer. Uses skset_pkg, skset_cell and skset_ctrl.
//
//   beat     ports                 qualifier            direction
//   command  mode, key             start && !busy       in
//   result   count, dropped,       done (one cycle)     out
//            removed
//
// Add: the key is shifted into the chain, result on done the next cycle; a new
// command can be taken every cycle.
// Erase: busy while the cell chain closes the matching slots (one matching
// slot closed per cycle), result on done in the first cycle that busy is low again.
// Reset clears every slot and the count; the result side cannot stall.
`default_nettype none
module sorted_key_set_insert_erase (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          mode,
	input  wire logic [skset_pkg::KEY_W-1:0]   key,
	output logic                               done,
	output logic [skset_pkg::OUT_W-1:0]        count,
	output logic                               dropped,
	output logic [skset_pkg::OUT_W-1:0]        removed
);

	skset_pkg::cell_ctrl_t                  ctrl;
	skset_pkg::cell_link_t                  links [skset_pkg::CAPACITY];
	logic [skset_pkg::CAPACITY-1:0]         hit_bits;
	logic [skset_pkg::CNT_W-1:0]            count_q;
	logic [skset_pkg::CNT_W-1:0]            removed_q;
	logic                                   done_q;
	logic                                   dropped_q;

	skset_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.key       (key),
		.any_match (|hit_bits),
		.busy      (busy),
		.ctrl      (ctrl),
		.count_q   (count_q),
		.done_q    (done_q),
		.dropped_q (dropped_q),
		.removed_q (removed_q)
	);

	for (genvar i = 0; i < skset_pkg::CAPACITY; i++) begin : g_cell
		skset_pkg::cell_pos_t  pos;
		skset_pkg::cell_link_t lo, hi;

		assign pos.valid = count_q > skset_pkg::CNT_W'(i);
		assign pos.tail  = count_q == skset_pkg::CNT_W'(i);

		if (i == 0) begin : g_lo_end
			assign lo = '0;
		end else begin : g_lo
			assign lo = links[i-1];
		end
		if (i == skset_pkg::CAPACITY - 1) begin : g_hi_end
			assign hi = '0;
		end else begin : g_hi
			assign hi = links[i+1];
		end

		skset_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.pos    (pos),
			.lo     (lo),
			.hi     (hi),
			.link   (links[i]),
			.match  (hit_bits[i])
		);
	end

	assign done    = done_q;
	assign dropped = dropped_q;
	assign count   = skset_pkg::OUT_W'(count_q);
	assign removed = skset_pkg::OUT_W'(removed_q);

endmodule
`default_nettype wire
